>>> sv/eh_callsite_table_parser_defines.svh
// Assertion macros used by the call-site table parser RTL.
// No dependencies; included by eh_callsite_table_parser.
`ifndef EH_CALLSITE_TABLE_PARSER_DEFINES_SVH
`define EH_CALLSITE_TABLE_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/eh_csp_pkg.sv
// Types and constants of the call-site table parser.
// No dependencies; used by eh_csp_uleb, eh_callsite_table_parser and the testbench.
package eh_csp_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned SHAMT_W    = $clog2(VALUE_BITS);
  localparam int unsigned WIDE_W     = VALUE_BITS + 7;
  localparam int unsigned SHIFT_W    = 7;
  localparam int unsigned SHIFT_SAT  = 70;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned COUNT_W    = 4;

  localparam int unsigned HDR_SKIP_BYTES = 8;
  localparam int unsigned HDR_LAST_IDX   = 10;
  localparam logic [7:0]  ENC_OMIT       = 8'hff;
  localparam logic [7:0]  ENC_ULEB128    = 8'h01;

  typedef enum logic [KIND_W-1:0] {
    KIND_RECORD     = 3'd0,
    KIND_BAD_HEADER = 3'd1,
    KIND_SHORT_BLOB = 3'd2,
    KIND_ACTION     = 3'd3,
    KIND_OVERFLOW   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ULEB_MORE,
    ULEB_DONE,
    ULEB_OVF
  } uleb_status_e;

  typedef struct packed {
    uleb_status_e            status;
    logic [VALUE_BITS-1:0]   value;
    logic [VALUE_BITS-1:0]   acc;
    logic [SHIFT_W-1:0]      shift;
  } uleb_step_t;

endpackage

>>> sv/eh_csp_uleb.sv
// One ULEB128 decode step: merge a byte into the running value.
// Depends on eh_csp_pkg.
module eh_csp_uleb (
  input  logic [7:0]                          data_i,
  input  logic [eh_csp_pkg::VALUE_BITS-1:0]   acc_i,
  input  logic [eh_csp_pkg::SHIFT_W-1:0]      shift_i,
  output eh_csp_pkg::uleb_step_t              step_o
);
  import eh_csp_pkg::*;

  logic [6:0]            payload;
  logic [WIDE_W-1:0]     wide;
  logic                  ovf;
  logic [VALUE_BITS-1:0] merged;
  logic [SHIFT_W-1:0]    shift_sum;

  always_comb begin
    payload   = data_i[6:0];
    wide      = WIDE_W'(payload) << shift_i[SHAMT_W-1:0];
    ovf       = (payload != 7'd0) &&
                ((shift_i >= SHIFT_W'(VALUE_BITS)) || (wide[WIDE_W-1:VALUE_BITS] != '0));
    merged    = acc_i | wide[VALUE_BITS-1:0];
    shift_sum = shift_i + SHIFT_W'(7);
    step_o.value = merged;
    if (ovf) begin
      step_o.status = ULEB_OVF;
      step_o.acc    = '0;
      step_o.shift  = '0;
    end else if (data_i[7]) begin
      step_o.status = ULEB_MORE;
      step_o.acc    = merged;
      step_o.shift  = (shift_sum > SHIFT_W'(SHIFT_SAT)) ? SHIFT_W'(SHIFT_SAT) : shift_sum;
    end else begin
      step_o.status = ULEB_DONE;
      step_o.acc    = '0;
      step_o.shift  = '0;
    end
  end

endmodule

>>> sv/eh_callsite_table_parser.sv
// Top level of the call-site table parser.
// Depends on eh_csp_pkg, eh_csp_uleb and eh_callsite_table_parser_defines.svh.
//
// Usage:
//   Slave channel: one blob byte per beat in s_axis_tdata_i, tlast on the
//   final byte of the blob. Master channel: one result beat per call-site
//   record or error; kind in tuser, call end and landing pad in tdata.
//   The block skips two header words, checks the three encoding bytes,
//   decodes the ULEB128 table length and then the call-site groups.
//   Throughput: one byte per cycle if not stalled; each byte is decoded by a
//   single ULEB128 step and the field state machine between the state registers
//   and the output register. Latency: a result is presented the cycle after
//   the byte that completes it. A result waits in the output register while
//   the receiver stalls; a new byte is taken in the same cycle the waiting
//   result is taken, so a stall of the master side stalls the slave side.
//   Reset empties the output register and arms the parser for a new blob;
//   there is no clearing pass. The tlast beat re-arms it likewise.
module eh_callsite_table_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [31:0] call_end, [63:32] lpad_offset
  output logic [2:0]  m_axis_tuser_o    // [2:0] kind
);
  import eh_csp_pkg::*;
  `include "eh_callsite_table_parser_defines.svh"

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_TABLE,
    PH_DONE
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [COUNT_W-1:0]    byte_count_q, byte_count_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [SHIFT_W-1:0]    shift_q, shift_d;
  logic [1:0]            field_idx_q, field_idx_d;
  logic [VALUE_BITS-1:0] begin_q, begin_d;
  logic [VALUE_BITS-1:0] length_q, length_d;
  logic [VALUE_BITS-1:0] pad_q, pad_d;
  logic [VALUE_BITS-1:0] remaining_q, remaining_d;
  logic                  error_seen_q, error_seen_d;

  logic                  out_valid_q;
  kind_e                 kind_q;
  logic [OUT_W-1:0]      call_end_q;
  logic [OUT_W-1:0]      lpad_offset_q;

  logic                  in_acc;
  logic                  res_valid;
  kind_e                 res_kind;
  logic [OUT_W-1:0]      res_end;
  logic [OUT_W-1:0]      res_pad;
  logic [VALUE_BITS:0]   sum;
  uleb_step_t            step;

  eh_csp_uleb u_uleb (
    .data_i  (s_axis_tdata_i),
    .acc_i   (acc_q),
    .shift_i (shift_q),
    .step_o  (step)
  );

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {lpad_offset_q, call_end_q};
  assign m_axis_tuser_o  = kind_q;

  always_comb begin
    phase_d      = phase_q;
    byte_count_d = byte_count_q;
    acc_d        = acc_q;
    shift_d      = shift_q;
    field_idx_d  = field_idx_q;
    begin_d      = begin_q;
    length_d     = length_q;
    pad_d        = pad_q;
    remaining_d  = remaining_q;
    error_seen_d = error_seen_q;
    res_valid    = 1'b0;
    res_kind     = KIND_RECORD;
    res_end      = '0;
    res_pad      = '0;
    sum          = {1'b0, begin_q} + {1'b0, length_q};

    if (!error_seen_q) begin
      case (phase_q)
        PH_HEADER: begin
          if (byte_count_q >= COUNT_W'(HDR_SKIP_BYTES)) begin
            if (s_axis_tdata_i != ((byte_count_q == COUNT_W'(HDR_LAST_IDX)) ?
                                   ENC_ULEB128 : ENC_OMIT)) begin
              res_valid = 1'b1;
              res_kind  = KIND_BAD_HEADER;
            end
          end
          byte_count_d = byte_count_q + COUNT_W'(1);
          if (byte_count_q >= COUNT_W'(HDR_LAST_IDX)) begin
            phase_d = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          acc_d   = step.acc;
          shift_d = step.shift;
          case (step.status)
            ULEB_OVF: begin
              res_valid = 1'b1;
              res_kind  = KIND_OVERFLOW;
            end
            ULEB_DONE: begin
              remaining_d = step.value;
              phase_d     = (step.value != '0) ? PH_TABLE : PH_DONE;
            end
            default: ;
          endcase
        end
        PH_TABLE: begin
          remaining_d = remaining_q - VALUE_BITS'(1);
          acc_d       = step.acc;
          shift_d     = step.shift;
          case (step.status)
            ULEB_OVF: begin
              res_valid = 1'b1;
              res_kind  = KIND_OVERFLOW;
            end
            ULEB_DONE: begin
              case (field_idx_q)
                2'd0: begin_d  = step.value;
                2'd1: length_d = step.value;
                2'd2: pad_d    = step.value;
                default: begin
                  if (step.value != '0) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_ACTION;
                  end else if (pad_q != '0) begin
                    res_valid = 1'b1;
                    if (sum[VALUE_BITS]) begin
                      res_kind = KIND_OVERFLOW;
                    end else begin
                      res_kind = KIND_RECORD;
                      res_end  = OUT_W'({{OUT_W{1'b0}}, sum[VALUE_BITS-1:0]});
                      res_pad  = OUT_W'({{OUT_W{1'b0}}, pad_q});
                    end
                  end
                end
              endcase
              field_idx_d = field_idx_q + 2'd1;
            end
            default: ;
          endcase
          if (remaining_d == '0) begin
            phase_d = PH_DONE;
          end
        end
        default: ;
      endcase
      if (res_valid && res_kind != KIND_RECORD) begin
        error_seen_d = 1'b1;
      end
    end

    if (s_axis_tlast_i) begin
      if ((!res_valid || res_kind == KIND_RECORD) && !error_seen_d &&
          (phase_d == PH_HEADER || phase_d == PH_LENGTH ||
           (phase_d == PH_TABLE && remaining_d != '0))) begin
        res_valid = 1'b1;
        res_kind  = KIND_SHORT_BLOB;
        res_end   = '0;
        res_pad   = '0;
      end
      phase_d      = PH_HEADER;
      byte_count_d = '0;
      acc_d        = '0;
      shift_d      = '0;
      field_idx_d  = '0;
      begin_d      = '0;
      length_d     = '0;
      pad_d        = '0;
      remaining_d  = '0;
      error_seen_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      byte_count_q <= '0;
      acc_q        <= '0;
      shift_q      <= '0;
      field_idx_q  <= '0;
      begin_q      <= '0;
      length_q     <= '0;
      pad_q        <= '0;
      remaining_q  <= '0;
      error_seen_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q      <= phase_d;
        byte_count_q <= byte_count_d;
        acc_q        <= acc_d;
        shift_q      <= shift_d;
        field_idx_q  <= field_idx_d;
        begin_q      <= begin_d;
        length_q     <= length_d;
        pad_q        <= pad_d;
        remaining_q  <= remaining_d;
        error_seen_q <= error_seen_d;
      end
      if (in_acc && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      kind_q        <= res_kind;
      call_end_q    <= res_end;
      lpad_offset_q <= res_pad;
    end
  end

  `EH_ASSERT_NEXT(a_last_rearms, clk_i, rst_ni, in_acc && s_axis_tlast_i,
    phase_q == PH_HEADER && byte_count_q == '0 && !error_seen_q,
    "parser not re-armed after the last byte")
  `EH_ASSERT_NOW(a_silent_after_error, clk_i, rst_ni, in_acc && error_seen_q,
    !res_valid, "result produced after an error in the same blob")
  `EH_ASSERT_NOW(a_error_payload_zero, clk_i, rst_ni,
    out_valid_q && kind_q != KIND_RECORD,
    call_end_q == '0 && lpad_offset_q == '0, "error beat carries a payload")
  `EH_ASSERT_NOW(a_shift_bounded, clk_i, rst_ni, 1'b1,
    shift_q <= SHIFT_W'(SHIFT_SAT), "ULEB128 shift beyond saturation")

endmodule

>>> dv/tb_eh_callsite_table_parser.sv
`timescale 1ns / 100ps
// Self-checking testbench for eh_callsite_table_parser: streams exception-table blobs in,
// predicts every call-site record and error beat, and compares the result stream.
// Depends on eh_csp_pkg and the eh_callsite_table_parser RTL.
module tb_eh_callsite_table_parser;
  import eh_csp_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } blob_beat_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] call_end;
    logic [31:0] lpad_offset;
  } site_result_t;

  typedef enum logic [1:0] {
    SCAN_HEADER,
    SCAN_LENGTH,
    SCAN_TABLE,
    SCAN_DONE
  } scan_phase_e;

  typedef enum logic [1:0] {
    GRP_BEGIN,
    GRP_LENGTH,
    GRP_PAD,
    GRP_ACTION
  } grp_field_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  eh_callsite_table_parser DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #6 clk_i = ~clk_i;

  blob_beat_t   pending_beats[$];
  site_result_t due_results[$];
  logic [7:0]   blob_bytes[$];
  logic [7:0]   site_bytes[$];
  logic [7:0]   uleb_buf[$];

  int unsigned  beats_offered = 0;
  int unsigned  beats_taken = 0;
  int unsigned  queued_beats = 0;
  int unsigned  mismatches = 0;
  int unsigned  in_idle_pct = 36;
  int unsigned  out_stall_pct = 84;

  blob_beat_t   drive_beat;
  site_result_t want_res;
  site_result_t got_res;

  // Parser state as predicted
  scan_phase_e  scan_ph;
  int unsigned  hdr_count;
  logic [63:0]  uleb_acc;
  int unsigned  uleb_shift;
  grp_field_e   grp_field;
  logic [63:0]  grp_begin;
  logic [63:0]  grp_len;
  logic [63:0]  grp_pad;
  logic [63:0]  tbl_left;
  bit           err_seen;

  function automatic logic [63:0] value_mask();
    return 64'hffff_ffff_ffff_ffff >> (64 - VALUE_BITS);
  endfunction

  function automatic void parser_rearm();
    scan_ph    = SCAN_HEADER;
    hdr_count  = 0;
    uleb_acc   = '0;
    uleb_shift = 0;
    grp_field  = GRP_BEGIN;
    grp_begin  = '0;
    grp_len    = '0;
    grp_pad    = '0;
    tbl_left   = '0;
    err_seen   = 1'b0;
  endfunction

  function automatic uleb_status_e uleb_take(input logic [7:0] b, output logic [63:0] val);
    logic [63:0] payload;
    int unsigned room;
    payload = {57'd0, b[6:0]};
    val = '0;
    if (payload != 0) begin
      room = (uleb_shift < VALUE_BITS) ? VALUE_BITS - uleb_shift : 0;
      if (uleb_shift >= VALUE_BITS || (room < 7 && (payload >> room) != 0)) begin
        uleb_acc   = '0;
        uleb_shift = 0;
        return ULEB_OVF;
      end
      uleb_acc |= payload << uleb_shift;
    end
    if (b[7]) begin
      uleb_shift += 7;
      if (uleb_shift > SHIFT_SAT) uleb_shift = SHIFT_SAT;
      return ULEB_MORE;
    end
    val        = uleb_acc & value_mask();
    uleb_acc   = '0;
    uleb_shift = 0;
    return ULEB_DONE;
  endfunction

  function automatic bit predict_site(input logic [7:0] b, input logic last,
                                      output site_result_t res);
    logic [63:0]  v;
    logic [63:0]  sum;
    bit           has;
    kind_e        k;
    uleb_status_e st;
    has = 1'b0;
    k   = KIND_RECORD;
    res.kind        = KIND_RECORD;
    res.call_end    = '0;
    res.lpad_offset = '0;
    if (!err_seen) begin
      case (scan_ph)
        SCAN_HEADER: begin
          if (hdr_count >= HDR_SKIP_BYTES &&
              b != ((hdr_count == HDR_LAST_IDX) ? ENC_ULEB128 : ENC_OMIT)) begin
            has = 1'b1;
            k   = KIND_BAD_HEADER;
          end
          hdr_count++;
          if (hdr_count > HDR_LAST_IDX) scan_ph = SCAN_LENGTH;
        end
        SCAN_LENGTH: begin
          st = uleb_take(b, v);
          if (st == ULEB_OVF) begin
            has = 1'b1;
            k   = KIND_OVERFLOW;
          end else if (st == ULEB_DONE) begin
            tbl_left = v;
            scan_ph  = (v != 0) ? SCAN_TABLE : SCAN_DONE;
          end
        end
        SCAN_TABLE: begin
          tbl_left--;
          st = uleb_take(b, v);
          if (st == ULEB_OVF) begin
            has = 1'b1;
            k   = KIND_OVERFLOW;
          end else if (st == ULEB_DONE) begin
            case (grp_field)
              GRP_BEGIN:  grp_begin = v;
              GRP_LENGTH: grp_len = v;
              GRP_PAD:    grp_pad = v;
              default: begin
                if (v != 0) begin
                  has = 1'b1;
                  k   = KIND_ACTION;
                end else if (grp_pad != 0) begin
                  sum = grp_begin + grp_len;
                  has = 1'b1;
                  if (sum < grp_begin || (sum & ~value_mask()) != 0) begin
                    k = KIND_OVERFLOW;
                  end else begin
                    res.call_end    = sum[31:0];
                    res.lpad_offset = grp_pad[31:0];
                  end
                end
              end
            endcase
            grp_field = grp_field_e'(grp_field + 2'd1);
          end
          if (tbl_left == 0) scan_ph = SCAN_DONE;
        end
        default: ;
      endcase
      if (has && k != KIND_RECORD) err_seen = 1'b1;
    end
    if (last) begin
      if (!err_seen && (scan_ph == SCAN_HEADER || scan_ph == SCAN_LENGTH ||
                        (scan_ph == SCAN_TABLE && tbl_left != 0))) begin
        has = 1'b1;
        k   = KIND_SHORT_BLOB;
      end
      parser_rearm();
    end
    if (k != KIND_RECORD) begin
      res.call_end    = '0;
      res.lpad_offset = '0;
    end
    res.kind = k;
    return has;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Blob construction
  function automatic void encode_uleb(input logic [63:0] v, input int pad);
    logic [63:0] rest;
    logic [7:0]  b;
    uleb_buf.delete();
    rest = v;
    forever begin
      b    = {1'b0, rest[6:0]};
      rest = rest >> 7;
      if (rest == 0) break;
      uleb_buf.push_back(b | 8'h80);
    end
    if (pad == 0) begin
      uleb_buf.push_back(b);
    end else begin
      uleb_buf.push_back(b | 8'h80);
      repeat (pad - 1) uleb_buf.push_back(8'h80);
      uleb_buf.push_back(8'h00);
    end
  endfunction

  function automatic void put_site(input logic [63:0] v, input int pad);
    encode_uleb(v, pad);
    foreach (uleb_buf[i]) site_bytes.push_back(uleb_buf[i]);
  endfunction

  function automatic void begin_blob();
    blob_bytes.delete();
    site_bytes.delete();
    repeat (HDR_SKIP_BYTES) blob_bytes.push_back(8'($urandom));
    blob_bytes.push_back(ENC_OMIT);
    blob_bytes.push_back(ENC_OMIT);
    blob_bytes.push_back(ENC_ULEB128);
  endfunction

  function automatic void seal_table(input logic [63:0] tbl_len, input int pad);
    encode_uleb(tbl_len, pad);
    foreach (uleb_buf[i]) blob_bytes.push_back(uleb_buf[i]);
    foreach (site_bytes[i]) blob_bytes.push_back(site_bytes[i]);
  endfunction

  function automatic void commit_blob(input int keep);
    blob_beat_t beat;
    int n;
    n = (keep > 0 && keep < blob_bytes.size()) ? keep : blob_bytes.size();
    for (int i = 0; i < n; i++) begin
      beat.data = blob_bytes[i];
      beat.last = (i == n - 1);
      pending_beats.push_back(beat);
    end
    queued_beats += n;
  endfunction

  function automatic logic [63:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) return 64'd0;
    if (sel < 50) return 64'($urandom_range(1, 127));
    if (sel < 72) return 64'($urandom_range(128, 65535));
    if (sel < 93) return {32'd0, 32'($urandom)};
    return 64'hffff_ffff;
  endfunction

  function automatic int pick_pad();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 88) return 0;
    if (sel < 98) return $urandom_range(1, 3);
    return $urandom_range(9, 12);
  endfunction

  function automatic void random_blob();
    logic [63:0] v;
    logic [63:0] tbl_len;
    int unsigned sel;
    int pos;
    int cut;
    if ($urandom_range(99) < 5) begin
      blob_bytes.delete();
      repeat ($urandom_range(1, 20)) blob_bytes.push_back(8'($urandom));
      commit_blob(0);
      return;
    end
    begin_blob();
    if ($urandom_range(99) < 6) begin
      pos = $urandom_range(HDR_SKIP_BYTES, HDR_LAST_IDX);
      blob_bytes[pos] = blob_bytes[pos] ^ 8'($urandom_range(1, 255));
    end
    repeat ($urandom_range(0, 5)) begin
      for (int f = 0; f < 4; f++) begin
        v = pick_value();
        if (f == 3) v = ($urandom_range(99) < 8) ? pick_value() : 64'd0;
        if ($urandom_range(99) < 3) v = v | (64'd1 << $urandom_range(VALUE_BITS, 63));
        put_site(v, pick_pad());
      end
    end
    tbl_len = 64'(site_bytes.size());
    sel = $urandom_range(99);
    if (sel < 8 && site_bytes.size() > 0)
      tbl_len -= 64'($urandom_range(1, site_bytes.size()));
    else if (sel >= 8 && sel < 14) tbl_len += 64'($urandom_range(1, 4));
    else if (sel >= 14 && sel < 18) tbl_len = 0;
    else if (sel >= 18 && sel < 20) tbl_len |= 64'd1 << $urandom_range(VALUE_BITS, 63);
    seal_table(tbl_len, pick_pad());
    if ($urandom_range(99) < 30) repeat ($urandom_range(1, 4)) blob_bytes.push_back(8'($urandom));
    cut = ($urandom_range(99) < 10) ? $urandom_range(1, blob_bytes.size()) : 0;
    commit_blob(cut);
  endfunction

  task automatic run_random(input int unsigned beats);
    int unsigned start;
    start = queued_beats;
    while (queued_beats - start < beats) random_blob();
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || beats_taken != beats_offered || due_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Driver: present beats and toggle the receiver's ready at the falling edge
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= out_stall_pct);
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (s_axis_tvalid_i && beats_taken != beats_offered) begin
      // hold the beat until it is taken
    end else if (pending_beats.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
      drive_beat = pending_beats.pop_front();
      beats_offered++;
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= drive_beat.data;
      s_axis_tlast_i  <= drive_beat.last;
    end else begin
      s_axis_tvalid_i <= 1'b0;
    end
  end

  // Monitor: check result beats, then predict from accepted input beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d tdata %h",
                                    m_axis_tuser_o, m_axis_tdata_o));
        end else begin
          want_res = due_results.pop_front();
          if (m_axis_tuser_o !== want_res.kind)
            report_mismatch($sformatf("kind %0d, want %0d", m_axis_tuser_o, want_res.kind));
          if (m_axis_tdata_o[31:0] !== want_res.call_end)
            report_mismatch($sformatf("call_end %h, want %h",
                                      m_axis_tdata_o[31:0], want_res.call_end));
          if (m_axis_tdata_o[63:32] !== want_res.lpad_offset)
            report_mismatch($sformatf("lpad_offset %h, want %h",
                                      m_axis_tdata_o[63:32], want_res.lpad_offset));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        beats_taken++;
        if (predict_site(s_axis_tdata_i, s_axis_tlast_i, got_res)) due_results.push_back(got_res);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    parser_rearm();
    in_idle_pct   = 36;
    out_stall_pct = 84;

    // Well-formed blob: extreme values, padded and saturated encodings, zero pad, trailing byte
    begin_blob();
    put_site(64'h7f, 0);
    put_site(64'h80, 0);
    put_site(64'hffff_ffff, 0);
    put_site(64'd0, 0);
    put_site(64'hffff_ffff, 0);
    put_site(64'd0, 2);
    put_site(64'd1, 12);
    put_site(64'd0, 0);
    put_site(64'd1, 0);
    put_site(64'd2, 0);
    put_site(64'd0, 0);
    put_site(64'd0, 0);
    seal_table(64'(site_bytes.size()), 1);
    blob_bytes.push_back(8'h5a);
    commit_blob(0);
    // Bad encoding byte, then bytes ignored until tlast
    begin_blob();
    blob_bytes[HDR_SKIP_BYTES + 1] = 8'hfe;
    blob_bytes.push_back(8'h00);
    commit_blob(0);
    // Blob ends inside the header
    begin_blob();
    commit_blob(5);
    // Nonzero action
    begin_blob();
    put_site(64'd1, 0);
    put_site(64'd1, 0);
    put_site(64'd1, 0);
    put_site(64'd5, 0);
    seal_table(64'(site_bytes.size()), 0);
    commit_blob(0);
    // Value wider than the parameter width
    begin_blob();
    put_site(64'h1_0000_0000, 0);
    put_site(64'd1, 0);
    put_site(64'd1, 0);
    put_site(64'd0, 0);
    seal_table(64'(site_bytes.size()), 0);
    commit_blob(0);
    // Call end does not fit
    begin_blob();
    put_site(64'hffff_ffff, 0);
    put_site(64'd1, 0);
    put_site(64'd1, 0);
    put_site(64'd0, 0);
    seal_table(64'(site_bytes.size()), 0);
    commit_blob(0);
    // Empty table, group bytes after it ignored
    begin_blob();
    put_site(64'd1, 0);
    put_site(64'd1, 0);
    put_site(64'd1, 0);
    put_site(64'd0, 0);
    seal_table(64'd0, 0);
    commit_blob(0);
    // Table longer than the blob
    begin_blob();
    put_site(64'd3, 0);
    put_site(64'd4, 0);
    put_site(64'd9, 0);
    put_site(64'd0, 0);
    seal_table(64'(site_bytes.size() + 6), 0);
    commit_blob(0);
    // Group cut by the table end
    begin_blob();
    put_site(64'd1, 0);
    put_site(64'd1, 0);
    put_site(64'd1, 0);
    put_site(64'd0, 0);
    seal_table(64'd3, 0);
    commit_blob(0);
    // Table length too wide
    begin_blob();
    seal_table(64'h8_0000_0000, 0);
    commit_blob(0);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_random(300);
    wait_drained();
    in_idle_pct   = 84;
    out_stall_pct = 36;
    run_random(300);
    wait_drained();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    run_random(300);
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
